// ----- rtl/engine_start_stop_sequencer_assert.svh -----
// assertion macros shared by the sequencer rtl
// each macro compiles to nothing when SYNTHESIS is defined
`ifndef ENGINE_START_STOP_SEQUENCER_ASSERT_SVH
`define ENGINE_START_STOP_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define ESS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ESS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESS_ASSERT(lbl, clk, rst_n, prop, msg)
`define ESS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/ess_pkg.sv -----
// shared constants and types for the engine start/stop sequencer
// no dependencies
package ess_pkg;

    localparam int NUM_REGS        = 7;
    localparam int PERIOD_W        = 16;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int TIMER_WIDTH_DEF = 16;

    // register indexes
    localparam logic [2:0] REG_INIT     = 3'd0;
    localparam logic [2:0] REG_DISC     = 3'd1;
    localparam logic [2:0] REG_START    = 3'd2;
    localparam logic [2:0] REG_RUN      = 3'd3;
    localparam logic [2:0] REG_POWER    = 3'd4;
    localparam logic [2:0] REG_ESTOP    = 3'd5;
    localparam logic [2:0] REG_SYSOFF   = 3'd6;

    typedef logic [NUM_REGS-1:0][PERIOD_W-1:0] t_periods;

    localparam t_periods PERIOD_RESET = {
        16'd5000,   // system off
        16'd30000,  // engine stop
        16'd10000,  // powering check
        16'd2000,   // running
        16'd25000,  // starting
        16'd10000,  // discovery
        16'd2000    // init
    };

endpackage

// ----- rtl/ess_if.sv -----
// stream channel interfaces for tick input and state/relay results
// no dependencies
interface ess_in_if;
    logic valid;
    logic ready;
    logic engine_idle;
    logic zero_current_trigger;
    logic zero_amps_measured;

    modport source (output valid, output engine_idle, output zero_current_trigger,
                    output zero_amps_measured, input ready);
    modport sink   (input valid, input engine_idle, input zero_current_trigger,
                    input zero_amps_measured, output ready);
endinterface

interface ess_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] state_code;
    logic       keep_alive;
    logic       mains_line;
    logic       fuel_valve;
    logic       starter;

    modport source (output valid, output state_code, output keep_alive, output mains_line,
                    output fuel_valve, output starter, input ready);
    modport sink   (input valid, input state_code, input keep_alive, input mains_line,
                    input fuel_valve, input starter, output ready);
endinterface

// ----- rtl/ess_regs.sv -----
// apb-style period register file for the sequencer
// depends on ess_pkg
module ess_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ess_pkg::ADDR_W-1:0]  paddr,
    input  logic [ess_pkg::DATA_W-1:0]  pwdata,
    output logic [ess_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ess_pkg::t_periods           o_periods
);

    ess_pkg::t_periods r_periods;
    logic [2:0]        w_index;
    logic              w_hit;
    logic              w_write;

    assign pready  = 1'b1;
    assign w_index = paddr[ess_pkg::ADDR_W-1:2];
    assign w_hit   = (w_index <= ess_pkg::REG_SYSOFF);
    assign w_write = psel && penable && pwrite && pready && w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periods <= ess_pkg::PERIOD_RESET;
        end else if (w_write) begin
            r_periods[w_index] <= pwdata[ess_pkg::PERIOD_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = {{(ess_pkg::DATA_W - ess_pkg::PERIOD_W){1'b0}}, r_periods[w_index]};
        end
    end

    assign o_periods = r_periods;

endmodule

// ----- rtl/ess_seq.sv -----
// sequencer core: input register, state/timer update, result register
// depends on ess_pkg, ess_if and the assertion header
`include "engine_start_stop_sequencer_assert.svh"

module ess_seq #(
    parameter int TIMER_WIDTH = ess_pkg::TIMER_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ess_in_if.sink            in_ch,
    ess_out_if.source         out_ch,
    input  ess_pkg::t_periods i_periods
);

    typedef enum logic [2:0] {
        ST_INIT   = 3'd0,
        ST_DISC   = 3'd1,
        ST_START  = 3'd2,
        ST_RUN    = 3'd3,
        ST_POWER  = 3'd4,
        ST_ESTOP  = 3'd5,
        ST_SYSOFF = 3'd6
    } t_state;

    // compare width covers both the counter and the period register
    localparam int CW = (TIMER_WIDTH > ess_pkg::PERIOD_W) ? TIMER_WIDTH : ess_pkg::PERIOD_W;
    localparam logic [TIMER_WIDTH-1:0] TICK_MAX = '1;
    localparam logic [CW-1:0] TICK_MAX_EXT = CW'(TICK_MAX);

    function automatic logic trig_match(input t_state st, input t_state trig);
        logic m;
        case (st)
            ST_INIT:  m = (trig == ST_DISC);
            ST_DISC:  m = (trig == ST_START) || (trig == ST_RUN);
            ST_START: m = (trig == ST_RUN);
            ST_RUN:   m = (trig == ST_POWER);
            ST_POWER: m = (trig == ST_ESTOP);
            ST_ESTOP: m = (trig == ST_SYSOFF);
            default:  m = (trig == ST_INIT);
        endcase
        return m;
    endfunction

    // input register
    logic r_in_valid, n_in_valid;
    logic r_in_idle, r_in_zc, r_in_za;

    // sequencer state
    t_state                 r_state, n_state;
    t_state                 r_trig, n_trig;
    logic [TIMER_WIDTH-1:0] r_tick, n_tick;
    logic                   r_ka, n_ka;

    // result register
    logic   r_out_valid, n_out_valid;
    t_state r_out_state;
    logic   r_out_ka, r_out_mains, r_out_fuel, r_out_starter;

    logic                   w_accept, w_advance, w_enter, w_fire;
    logic [2:0]             w_pidx;
    logic [CW-1:0]          w_period_ext, w_period;
    logic [TIMER_WIDTH-1:0] w_tick_base, w_tick_inc;
    logic                   n_mains, n_fuel, n_starter;

    assign w_advance    = r_in_valid && (!r_out_valid || out_ch.ready);
    assign in_ch.ready  = !r_in_valid || w_advance;
    assign w_accept     = in_ch.valid && in_ch.ready;

    assign n_in_valid   = w_accept ? 1'b1 : (w_advance ? 1'b0 : r_in_valid);
    assign n_out_valid  = w_advance ? 1'b1 : (out_ch.ready ? 1'b0 : r_out_valid);

    always_comb begin
        w_enter = trig_match(r_state, r_trig);
        n_state = w_enter ? r_trig : r_state;
        w_tick_base = w_enter ? '0 : r_tick;

        // unknown state code times like system off
        w_pidx = (n_state == ST_SYSOFF || n_state == ST_INIT || n_state == ST_DISC ||
                  n_state == ST_START || n_state == ST_RUN || n_state == ST_POWER ||
                  n_state == ST_ESTOP) ? n_state : ess_pkg::REG_SYSOFF;
        w_period_ext = CW'(i_periods[w_pidx]);
        // period beyond a narrow counter saturates at its maximum
        w_period = (w_period_ext > TICK_MAX_EXT) ? TICK_MAX_EXT : w_period_ext;

        w_tick_inc = (w_tick_base != TICK_MAX) ? w_tick_base + 1'b1 : w_tick_base;
        w_fire = (CW'(w_tick_inc) >= w_period);
        n_tick = w_fire ? '0 : w_tick_inc;

        n_trig    = r_trig;
        n_ka      = r_ka;
        n_mains   = 1'b0;
        n_fuel    = 1'b0;
        n_starter = 1'b0;
        case (n_state)
            ST_INIT: begin
                n_ka = 1'b0;
                if (w_fire) n_trig = ST_DISC;
            end
            ST_DISC: begin
                n_ka = 1'b1;
                if (w_fire) n_trig = r_in_idle ? ST_START : ST_RUN;
            end
            ST_START: begin
                n_ka = 1'b1; n_mains = 1'b1; n_fuel = 1'b1; n_starter = 1'b1;
                if (w_fire) n_trig = ST_RUN;
            end
            ST_RUN: begin
                n_ka = 1'b1; n_mains = 1'b1; n_fuel = 1'b1;
                if (w_fire) n_trig = ST_POWER;
            end
            ST_POWER: begin
                n_ka = 1'b1; n_mains = 1'b1; n_fuel = 1'b1;
                if (w_fire && (r_in_zc || r_in_za)) n_trig = ST_ESTOP;
            end
            ST_ESTOP: begin
                n_ka = 1'b1; n_mains = 1'b1;
                if (w_fire) n_trig = ST_SYSOFF;
            end
            default: begin
                // keep-alive drops when the final timer fires
                if (w_fire) n_ka = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= ST_INIT;
            r_trig      <= ST_INIT;
            r_tick      <= '0;
            r_ka        <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_advance) begin
                r_state <= n_state;
                r_trig  <= n_trig;
                r_tick  <= n_tick;
                r_ka    <= n_ka;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_idle <= in_ch.engine_idle;
            r_in_zc   <= in_ch.zero_current_trigger;
            r_in_za   <= in_ch.zero_amps_measured;
        end
        if (w_advance) begin
            r_out_state   <= n_state;
            r_out_ka      <= n_ka;
            r_out_mains   <= n_mains;
            r_out_fuel    <= n_fuel;
            r_out_starter <= n_starter;
        end
    end

    assign out_ch.valid      = r_out_valid;
    assign out_ch.state_code = r_out_state;
    assign out_ch.keep_alive = r_out_ka;
    assign out_ch.mains_line = r_out_mains;
    assign out_ch.fuel_valve = r_out_fuel;
    assign out_ch.starter    = r_out_starter;

    `ESS_ASSERT(a_state_holds, i_clk, i_rst_n, i_rst_n && !w_advance |=> $stable(r_state), "state moved without a tick transfer")
    `ESS_ASSERT(a_entry_restarts, i_clk, i_rst_n, i_rst_n && w_advance && w_enter |=> r_tick <= TIMER_WIDTH'(1), "timer not restarted on state entry")
    `ESS_ASSERT(a_sysoff_final, i_clk, i_rst_n, i_rst_n && r_state == ST_SYSOFF |=> r_state == ST_SYSOFF, "left system off state")
    `ESS_ASSERT(a_init_relays_off, i_clk, i_rst_n, r_out_valid && r_out_state == ST_INIT |-> !r_out_ka && !r_out_mains && !r_out_fuel && !r_out_starter, "relay driven in init")

endmodule

// ----- rtl/engine_start_stop_sequencer.sv -----
// top level of the engine start/stop sequencer
// depends on ess_pkg, ess_if, ess_regs and ess_seq

// One input transfer is one millisecond tick carrying the engine-idle and
// zero-current flags; each tick returns one result with the state code and
// the four relay levels (keep-alive, mains line, fuel valve, starter). A tick
// is accepted into the input register and its result is presented from the
// result register, with the single-pass state/timer update and period compare
// between them, so ticks can follow back to back. A result waiting on a stalled
// receiver keeps the tick behind it in the input register; the input is held
// off only while both registers are full. The seven per-state periods sit in
// an APB-style register file at byte addresses 4*i and should be written only
// while no tick is in flight.
module engine_start_stop_sequencer #(
    parameter int TIMER_WIDTH = ess_pkg::TIMER_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    ess_in_if.sink                     in_ch,
    ess_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ess_pkg::ADDR_W-1:0] paddr,
    input  logic [ess_pkg::DATA_W-1:0] pwdata,
    output logic [ess_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    ess_pkg::t_periods w_periods;

    ess_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_periods (w_periods)
    );

    ess_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .i_periods (w_periods)
    );

endmodule

// ----- test/tb_engine_start_stop_sequencer.sv -----
// self-checking testbench for the engine start/stop sequencer: ticks in, state and relays out
// depends on ess_pkg, ess_if and the engine_start_stop_sequencer rtl
// a local copy of the sequence rules predicts every result; periods are set over the apb port
module tb_engine_start_stop_sequencer;

    localparam int                TMR_W       = ess_pkg::TIMER_WIDTH_DEF;
    localparam longint unsigned   CNT_MAX     = (64'd1 << TMR_W) - 1;
    localparam int                HOLD_PHASES = 8;
    localparam int                HOLD_TICKS  = 130;
    localparam int                CYCLE_LIMIT = 400000;
    localparam logic [2:0]        REG_NONE    = 3'd7;

    typedef enum logic [2:0] {
        S_INIT, S_DISC, S_START, S_RUN, S_POWER, S_ESTOP, S_SYSOFF
    } t_seq_state;

    typedef struct packed {
        logic [2:0] state_code;
        logic       keep_alive;
        logic       mains_line;
        logic       fuel_valve;
        logic       starter;
    } t_seq_result;

    typedef struct packed {
        logic        typed;
        t_seq_result drives;
    } t_typed_drive;

    typedef enum logic { ROW_TICK, ROW_WRITE } t_row_kind;

    // flags are {engine_idle, zero_current_trigger, zero_amps_measured}
    typedef struct packed {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [15:0] value;
        logic [2:0]  flags;
        logic        typed;
        t_seq_result drives;
    } t_script_row;

    typedef enum { RX_OPEN, RX_LIGHT, RX_HEAVY, RX_COMB } t_rx_mode;

    localparam t_seq_result DRIVES_OFF   = '{S_INIT, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam t_seq_result DRIVES_POWER = '{S_POWER, 1'b1, 1'b1, 1'b1, 1'b0};

    localparam t_script_row SCRIPT [26] = '{
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b000, 1'b1, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b001, 1'b1, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b010, 1'b1, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b011, 1'b1, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b100, 1'b1, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b101, 1'b1, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b110, 1'b1, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b111, 1'b1, DRIVES_OFF},
        // zero period in init, short periods through to powering
        '{ROW_WRITE, ess_pkg::REG_INIT,   16'd0,    3'b000, 1'b0, DRIVES_OFF},
        '{ROW_WRITE, ess_pkg::REG_DISC,   16'd1,    3'b000, 1'b0, DRIVES_OFF},
        '{ROW_WRITE, ess_pkg::REG_START,  16'd2,    3'b000, 1'b0, DRIVES_OFF},
        '{ROW_WRITE, ess_pkg::REG_RUN,    16'd1,    3'b000, 1'b0, DRIVES_OFF},
        '{ROW_WRITE, ess_pkg::REG_POWER,  16'hFFFF, 3'b000, 1'b0, DRIVES_OFF},
        '{ROW_WRITE, ess_pkg::REG_ESTOP,  16'd3,    3'b000, 1'b0, DRIVES_OFF},
        '{ROW_WRITE, ess_pkg::REG_SYSOFF, 16'd4,    3'b000, 1'b0, DRIVES_OFF},
        '{ROW_WRITE, REG_NONE,            16'h5A5A, 3'b000, 1'b0, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b000, 1'b0, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b100, 1'b0, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b000, 1'b0, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b011, 1'b0, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b000, 1'b0, DRIVES_OFF},
        // longest check period: zero-current flags cannot act yet
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b011, 1'b1, DRIVES_POWER},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b111, 1'b1, DRIVES_POWER},
        // checks that find current flowing leave a stale trigger behind
        '{ROW_WRITE, ess_pkg::REG_POWER,  16'd1,    3'b000, 1'b0, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b000, 1'b0, DRIVES_OFF},
        '{ROW_TICK,  ess_pkg::REG_INIT,   16'd0,    3'b100, 1'b0, DRIVES_OFF}
    };

    localparam string REG_LABEL [ess_pkg::NUM_REGS] = '{
        "init_ticks", "discovery_ticks", "starting_ticks", "running_ticks",
        "powering_check_ticks", "engine_stop_ticks", "system_off_ticks"
    };

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ess_pkg::ADDR_W-1:0]  paddr;
    logic [ess_pkg::DATA_W-1:0]  pwdata;
    logic [ess_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    ess_in_if  in_ch ();
    ess_out_if out_ch ();

    engine_start_stop_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // sequencer copy: state, timer, pending trigger, keep-alive and periods
    t_seq_state       m_state;
    t_seq_state       m_pend;
    longint unsigned  m_cnt;
    logic             m_ka;
    logic [15:0]      m_period [ess_pkg::NUM_REGS];

    t_seq_result      pending_drives [$];
    t_typed_drive     typed_drives [$];
    int               fault_count;
    int               tick_total;
    int               result_total;
    int               write_total;
    int               setting_total;
    int               cycle_count;
    int               burst_left;

    function automatic logic trigger_opens(input t_seq_state s, input t_seq_state t);
        case (s)
            S_INIT:  return t == S_DISC;
            S_DISC:  return t == S_START || t == S_RUN;
            S_START: return t == S_RUN;
            S_RUN:   return t == S_POWER;
            S_POWER: return t == S_ESTOP;
            S_ESTOP: return t == S_SYSOFF;
            default: return t == S_INIT;
        endcase
    endfunction

    function automatic longint unsigned period_of(input t_seq_state s);
        longint unsigned p;
        p = (s > S_SYSOFF) ? m_period[S_SYSOFF] : m_period[s];
        return (p > CNT_MAX) ? CNT_MAX : p;
    endfunction

    function automatic t_seq_result sequence_tick(input logic idle, input logic zc,
                                                  input logic za);
        t_seq_state  s;
        logic        fire;
        t_seq_result r;
        s = m_state;
        if (trigger_opens(s, m_pend)) begin
            s       = m_pend;
            m_state = s;
            m_cnt   = 0;
        end
        if (m_cnt < CNT_MAX) m_cnt++;
        fire = (m_cnt >= period_of(s));
        if (fire) m_cnt = 0;
        r = '0;
        r.state_code = s;
        case (s)
            S_INIT: begin
                m_ka = 1'b0;
                if (fire) m_pend = S_DISC;
            end
            S_DISC: begin
                m_ka = 1'b1;
                if (fire) m_pend = idle ? S_START : S_RUN;
            end
            S_START: begin
                m_ka = 1'b1;
                {r.mains_line, r.fuel_valve, r.starter} = 3'b111;
                if (fire) m_pend = S_RUN;
            end
            S_RUN: begin
                m_ka = 1'b1;
                {r.mains_line, r.fuel_valve} = 2'b11;
                if (fire) m_pend = S_POWER;
            end
            S_POWER: begin
                m_ka = 1'b1;
                {r.mains_line, r.fuel_valve} = 2'b11;
                if (fire && (zc || za)) m_pend = S_ESTOP;
            end
            S_ESTOP: begin
                m_ka = 1'b1;
                r.mains_line = 1'b1;
            end
            default: begin
                if (fire) m_ka = 1'b0;
            end
        endcase
        if (s == S_ESTOP && fire) m_pend = S_SYSOFF;
        r.keep_alive = m_ka;
        return r;
    endfunction

    // true when the next tick lands on a powering check
    function automatic logic power_timer_due();
        t_seq_state      s;
        longint unsigned c;
        s = m_state;
        c = m_cnt;
        if (trigger_opens(m_state, m_pend)) begin
            s = m_pend;
            c = 0;
        end
        if (c < CNT_MAX) c++;
        return (s == S_POWER) && (c >= period_of(s));
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'($urandom);
            default: return 16'($urandom_range(2, 9));
        endcase
    endfunction

    task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [15:0] data,
                              output logic [15:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ess_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= {{(ess_pkg::DATA_W-16){1'b0}}, data};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata[15:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_period(input logic [2:0] idx, input logic [15:0] value);
        logic [15:0] unused;
        apb_access(1'b1, idx, value, unused);
        if (idx < ess_pkg::NUM_REGS) m_period[idx] = value;
        write_total++;
    endtask

    task automatic check_periods();
        logic [15:0] rd;
        for (int i = 0; i < ess_pkg::NUM_REGS; i++) begin
            apb_access(1'b0, 3'(i), 16'h0, rd);
            compare_field({REG_LABEL[i], " readback"}, m_period[i], rd);
        end
        setting_total++;
    endtask

    // stop sending and wait for every predicted result to come back
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_drives.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid                <= 1'b0;
                in_ch.engine_idle          <= 1'($urandom);
                in_ch.zero_current_trigger <= 1'($urandom);
                in_ch.zero_amps_measured   <= 1'($urandom);
            end
        end
        burst_left--;
    endtask

    // hold keeps the zero-current flags low on a powering check so the stay goes on
    task automatic send_tick(input logic [2:0] fl, input logic hold, input logic typed,
                             input t_seq_result want);
        logic [2:0] f;
        @(negedge i_clk);
        f = fl;
        if (hold && power_timer_due()) f[1:0] = 2'b00;
        in_ch.valid                <= 1'b1;
        in_ch.engine_idle          <= f[2];
        in_ch.zero_current_trigger <= f[1];
        in_ch.zero_amps_measured   <= f[0];
        typed_drives.push_back('{typed, want});
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver stalls follow a mode that is picked anew at random after each span
    initial begin
        t_rx_mode mode;
        int       span;
        int       beat;
        out_ch.ready = 1'b0;
        beat = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    RX_OPEN:  out_ch.ready <= 1'b1;
                    RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:  out_ch.ready <= (beat % 5 != 0);
                endcase
                beat++;
            end
        end
    end

    // input transfers feed the predictor first, then output transfers are compared
    always @(posedge i_clk) begin
        t_seq_result  want;
        t_seq_result  got;
        t_typed_drive note;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                want = sequence_tick(in_ch.engine_idle, in_ch.zero_current_trigger,
                                     in_ch.zero_amps_measured);
                tick_total++;
                if (typed_drives.size() != 0) begin
                    note = typed_drives.pop_front();
                    if (note.typed) want = note.drives;
                end
                pending_drives.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                result_total++;
                got = '{out_ch.state_code, out_ch.keep_alive, out_ch.mains_line,
                        out_ch.fuel_valve, out_ch.starter};
                if (pending_drives.size() == 0) begin
                    $error("result transfer with no tick outstanding");
                    fault_count++;
                end else begin
                    want = pending_drives.pop_front();
                    compare_field("state_code", want.state_code, got.state_code);
                    compare_field("keep_alive", want.keep_alive, got.keep_alive);
                    compare_field("mains_line", want.mains_line, got.mains_line);
                    compare_field("fuel_valve", want.fuel_valve, got.fuel_valve);
                    compare_field("starter", want.starter, got.starter);
                end
            end
        end
    end

    initial begin
        logic fresh_regs;
        i_rst_n                    = 1'b0;
        in_ch.valid                = 1'b0;
        in_ch.engine_idle          = 1'b0;
        in_ch.zero_current_trigger = 1'b0;
        in_ch.zero_amps_measured   = 1'b0;
        psel                       = 1'b0;
        penable                    = 1'b0;
        pwrite                     = 1'b0;
        paddr                      = '0;
        pwdata                     = '0;
        fault_count   = 0;
        tick_total    = 0;
        result_total  = 0;
        write_total   = 0;
        setting_total = 0;
        cycle_count   = 0;
        burst_left    = 0;
        m_state       = S_INIT;
        m_pend        = S_INIT;
        m_cnt         = 0;
        m_ka          = 1'b0;
        for (int i = 0; i < ess_pkg::NUM_REGS; i++) m_period[i] = ess_pkg::PERIOD_RESET[i];

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_periods();
        fresh_regs = 1'b0;
        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].kind == ROW_WRITE) begin
                settle();
                write_period(SCRIPT[i].idx, SCRIPT[i].value);
                fresh_regs = 1'b1;
            end else begin
                if (fresh_regs) begin
                    check_periods();
                    fresh_regs = 1'b0;
                end
                pace();
                send_tick(SCRIPT[i].flags, 1'b0, SCRIPT[i].typed, SCRIPT[i].drives);
            end
        end

        // long stay in powering house under changing periods
        for (int p = 0; p < HOLD_PHASES; p++) begin
            settle();
            for (int reg_i = 0; reg_i < ess_pkg::NUM_REGS; reg_i++) begin
                write_period(3'(reg_i), pick_period());
            end
            if ($urandom_range(0, 1)) write_period(REG_NONE, 16'($urandom));
            check_periods();
            repeat (HOLD_TICKS) begin
                pace();
                send_tick(3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
            end
        end

        // free flags: leave powering, stop the engine, shut the system off
        settle();
        write_period(ess_pkg::REG_POWER, 16'($urandom_range(0, 5)));
        write_period(ess_pkg::REG_ESTOP, 16'($urandom_range(0, 5)));
        write_period(ess_pkg::REG_SYSOFF, 16'($urandom_range(2, 12)));
        check_periods();
        repeat (150) begin
            pace();
            send_tick(3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
        end

        for (int e = 0; e < 2; e++) begin
            settle();
            write_period(ess_pkg::REG_SYSOFF, (e == 0) ? 16'hFFFF : 16'h0000);
            check_periods();
            repeat (30) begin
                pace();
                send_tick(3'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (pending_drives.size() != 0) begin
            $error("%0d results never arrived", pending_drives.size());
            fault_count++;
        end
        $display("%0d ticks over %0d period settings, %0d results compared, %0d register writes",
                 tick_total, setting_total, result_total, write_total);
        $display("sequence ended in state %0d with keep-alive at %0b", m_state, m_ka);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
